// ===== sv/swm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window max/min/mean unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int PRICE_W = 32;   // price and result field width, cents
    localparam int CFG_W   = 7;    // window length register width
    localparam int LEN_RST = 20;   // window length after reset

    typedef logic [PRICE_W-1:0] t_price;
    typedef logic [CFG_W-1:0]   t_cfg;

endpackage

// ===== sv/sliding_window_max_min_mean_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max_min_mean_unit
// Max, min and truncated mean of the preceding window of closing prices.
//
// Input channel: i_in_valid / o_in_stall with i_close_price, one price a beat.
// Output channel: o_out_valid / i_out_stall with window max, min and mean.
// Config channel: i_cfg_valid / o_cfg_ready with i_window_len; accepted only
// while the unit is idle, ahead of a price offered in the same cycle. A write
// empties the window (length 0 acts as 1, lengths above MAX_WINDOW clamp).
// Until the window has seen window_len prices a price gives no result and
// is only written into the ring. After that each price is first scanned
// and divided and then loaded as a result: a scan of the ring RAM, one
// entry per cycle, then a bit-serial divide of the running sum, one bit
// per cycle.
// The result sits in an output register; if the receiver stalls, the next
// price is still taken and scanned, and waits only before loading its result.
// Reset empties the window and sets the length to 20; the ring RAM is not
// cleared, every slot is written before it is read.
// ----------------------------------------------------------------------------
module sliding_window_max_min_mean_unit #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  swm_pkg::t_price       i_close_price,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output swm_pkg::t_price       o_window_max,
    output swm_pkg::t_price       o_window_min,
    output swm_pkg::t_price       o_window_mean,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  swm_pkg::t_cfg         i_window_len
);

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int CW    = (LW > swm_pkg::CFG_W) ? LW : swm_pkg::CFG_W;
    localparam int SUM_W = swm_pkg::PRICE_W + $clog2(MAX_WINDOW);
    localparam int LEN_RST_C =
        (swm_pkg::LEN_RST > MAX_WINDOW) ? MAX_WINDOW : swm_pkg::LEN_RST;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [LW-1:0]    r_len, n_len;
    logic [AW-1:0]    r_slot, n_slot;
    logic [LW-1:0]    r_seen, n_seen;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [LW-1:0]    r_cnt, n_cnt;
    logic             r_full, n_full;
    logic             r_rd_vld, n_rd_vld;
    logic [AW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_out_valid, n_out_valid;

    swm_pkg::t_price  r_price, n_price;
    swm_pkg::t_price  r_hi, n_hi;
    swm_pkg::t_price  r_lo, n_lo;
    swm_pkg::t_price  r_old, n_old;
    swm_pkg::t_price  r_max, n_max;
    swm_pkg::t_price  r_min, n_min;
    swm_pkg::t_price  r_mean, n_mean;

    logic             rd_en;
    logic             wr_en;
    swm_pkg::t_price  rd_data;
    logic             div_start;
    logic             div_done;
    swm_pkg::t_price  div_quo;
    logic [CW-1:0]    cfg_ext;
    logic [CW-1:0]    cfg_len;
    logic [LW-1:0]    slot_inc;
    logic             cfg_wr;

    swm_ram #(
        .WIDTH (swm_pkg::PRICE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_price),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cnt[AW-1:0]),
        .o_rd_data (rd_data)
    );

    swm_div #(
        .DVD_W (SUM_W),
        .DVS_W (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // a pending config write holds off the price beat
    assign o_in_stall  = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        cfg_ext = CW'(i_window_len);
        if (cfg_ext == '0) begin
            cfg_len = CW'(1);
        end else if (cfg_ext > CW'(MAX_WINDOW)) begin
            cfg_len = CW'(MAX_WINDOW);
        end else begin
            cfg_len = cfg_ext;
        end
    end

    assign slot_inc = LW'(r_slot) + LW'(1);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_slot      = r_slot;
        n_seen      = r_seen;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        n_price     = r_price;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_old       = r_old;
        n_max       = r_max;
        n_min       = r_min;
        n_mean      = r_mean;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        div_start   = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // read data lands in the cycle after the address
        if (r_rd_vld) begin
            if (r_rd_idx == '0) begin
                n_hi = rd_data;
                n_lo = rd_data;
            end else begin
                if (rd_data > r_hi) begin
                    n_hi = rd_data;
                end
                if (rd_data < r_lo) begin
                    n_lo = rd_data;
                end
            end
            if (r_rd_idx == r_slot) begin
                n_old = rd_data;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_price = i_close_price;
                    n_full  = (r_seen >= r_len);
                    n_cnt   = '0;
                    n_state = (r_seen >= r_len) ? ST_SCAN : ST_WRITE;
                end
            end
            ST_SCAN: begin
                if (r_cnt < r_len) begin
                    rd_en = 1'b1;
                    n_cnt = r_cnt + LW'(1);
                end
                if (r_rd_vld && (LW'(r_rd_idx) == r_len - LW'(1))) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_max       = r_hi;
                    n_min       = r_lo;
                    n_mean      = div_quo;
                    n_out_valid = 1'b1;
                    n_state     = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_en = 1'b1;
                if (r_full) begin
                    n_sum = r_sum - SUM_W'(r_old) + SUM_W'(r_price);
                end else begin
                    n_sum  = r_sum + SUM_W'(r_price);
                    n_seen = r_seen + LW'(1);
                end
                n_slot  = (slot_inc >= r_len) ? '0 : slot_inc[AW-1:0];
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // new length empties the window
        if (cfg_wr) begin
            n_len  = cfg_len[LW-1:0];
            n_slot = '0;
            n_seen = '0;
            n_sum  = '0;
        end
    end

    assign n_rd_vld = rd_en;
    assign n_rd_idx = r_cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= LW'(LEN_RST_C);
            r_slot      <= '0;
            r_seen      <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_full      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_slot      <= n_slot;
            r_seen      <= n_seen;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_full      <= n_full;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_price  <= n_price;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_old    <= n_old;
        r_max    <= n_max;
        r_min    <= n_min;
        r_mean   <= n_mean;
    end

    assign o_out_valid   = r_out_valid;
    assign o_window_max  = r_max;
    assign o_window_min  = r_min;
    assign o_window_mean = r_mean;

endmodule

// ===== sv/swm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/swm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is
// held on o_quotient from the o_done pulse until the next start.
// ----------------------------------------------------------------------------
module swm_div #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DVD_W-1:0]    i_dividend,
    input  logic [DVS_W-1:0]    i_divisor,
    output logic                o_done,
    output swm_pkg::t_price     o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb begin
        trial  = {r_rem, r_quo[DVD_W-1]};
        fits   = (trial >= {1'b0, i_divisor});
        diff   = trial - {1'b0, i_divisor};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], fits};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[swm_pkg::PRICE_W-1:0];

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window max/min/mean unit.
//
// Prices go in one beat at a time. A local model of the price ring, fill count
// and running sum predicts, per accepted beat, whether a window result is due
// and what max, min and truncated mean it carries. Results are matched in
// order against those predictions. Window lengths are changed only while the
// unit is drained, and cover zero, one, the ring size and values past it.
// Sender gaps and receiver stalls vary by phase, and one long receiver
// hold-off backs the unit up into its input.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_WINDOW   = 64;
    localparam int DRAIN_CYCLES = 120;     // longest scan plus divide, with margin
    localparam int HOLD_CYCLES  = 1500;
    localparam int RANDOM_ITEMS = 1140;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace_mode;

    typedef struct packed {
        swm_pkg::t_price max_p;
        swm_pkg::t_price min_p;
        swm_pkg::t_price mean_p;
    } t_window_stats;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_in_valid    = 1'b0;
    swm_pkg::t_price i_close_price = '0;
    logic            i_out_stall   = 1'b0;
    logic            i_cfg_valid   = 1'b0;
    swm_pkg::t_cfg   i_window_len  = '0;
    logic            o_in_stall;
    logic            o_out_valid;
    swm_pkg::t_price o_window_max;
    swm_pkg::t_price o_window_min;
    swm_pkg::t_price o_window_mean;
    logic            o_cfg_ready;

    // window model
    swm_pkg::t_price ring_price [MAX_WINDOW];
    int unsigned     next_slot  = 0;
    int unsigned     fill_count = 0;
    logic [63:0]     ring_sum   = '0;
    swm_pkg::t_cfg   len_reg    = swm_pkg::t_cfg'(swm_pkg::LEN_RST);

    t_window_stats pending_stats [$];
    int            errors         = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_reqs      = 0;
    int            hold_taken     = 0;
    int            hold_left      = 0;

    sliding_window_max_min_mean_unit #(
        .MAX_WINDOW(MAX_WINDOW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_close_price (i_close_price),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_window_max  (o_window_max),
        .o_window_min  (o_window_min),
        .o_window_mean (o_window_mean),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_window_len  (i_window_len)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned clamp_len(input swm_pkg::t_cfg len);
        if (len == 0) begin
            return 1;
        end
        if (len > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return 32'(len);
    endfunction

    // Advance the window by one price; returns 1 when a result is due.
    function automatic bit slide_window(input swm_pkg::t_price price,
                                        output t_window_stats stats);
        int unsigned     len;
        int unsigned     slot;
        swm_pkg::t_price hi;
        swm_pkg::t_price lo;
        bit              due;
        len   = clamp_len(len_reg);
        slot  = (next_slot >= len) ? 0 : next_slot;
        due   = 1'b0;
        stats = '0;
        if (fill_count >= len) begin
            hi = ring_price[0];
            lo = ring_price[0];
            for (int k = 1; k < len; k++) begin
                if (ring_price[k] > hi) begin
                    hi = ring_price[k];
                end
                if (ring_price[k] < lo) begin
                    lo = ring_price[k];
                end
            end
            stats.max_p  = hi;
            stats.min_p  = lo;
            stats.mean_p = swm_pkg::t_price'(ring_sum / len);
            ring_sum     = ring_sum - ring_price[slot];
            due          = 1'b1;
        end else begin
            fill_count++;
        end
        ring_price[slot] = price;
        ring_sum         = ring_sum + price;
        slot++;
        next_slot = (slot >= len) ? 0 : slot;
        return due;
    endfunction

    function automatic void check_field(input string name, input swm_pkg::t_price want,
                                        input swm_pkg::t_price got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic swm_pkg::t_price rand_price();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return '0;
        end
        if (pick < 20) begin
            return '1;
        end
        if (pick < 30) begin
            return swm_pkg::t_price'($urandom_range(1000));
        end
        return $urandom;
    endfunction

    task automatic set_pacing(input t_pace_mode mode);
        case (mode)
            PACE_FULL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct  = 76;
                recv_stall_pct = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 76;
            end
            default: begin
                send_idle_pct  = 6;
                recv_stall_pct = 6;
            end
        endcase
    endtask

    // One price beat; valid stays up after acceptance for back-to-back beats.
    task automatic send_price(input swm_pkg::t_price price);
        t_window_stats stats;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_close_price <= price;
        do @(posedge i_clk); while (o_in_stall);
        if (slide_window(price, stats)) begin
            pending_stats.push_back(stats);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_stats.size() != 0) begin
            @(posedge i_clk);
        end
        // a last price with no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window_len(input swm_pkg::t_cfg len);
        wait_drained();
        i_cfg_valid  <= 1'b1;
        i_window_len <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        len_reg    = len;
        next_slot  = 0;
        fill_count = 0;
        ring_sum   = '0;
    endtask

    // Receiver side: random stalls, or a counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_taken != hold_reqs) begin
            hold_taken  <= hold_reqs;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_window_stats want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h %h %h",
                         $time, o_window_max, o_window_min, o_window_mean);
                errors++;
            end else begin
                want = pending_stats.pop_front();
                check_field("window_max", want.max_p, o_window_max);
                check_field("window_min", want.min_p, o_window_min);
                check_field("window_mean", want.mean_p, o_window_mean);
            end
        end
    end

    // Length after reset is 20: 20 prices fill the window, then two results.
    task automatic test_reset_length();
        for (int i = 0; i < 22; i++) begin
            send_price((i == 0) ? swm_pkg::t_price'('0) :
                       (i == 1) ? swm_pkg::t_price'('1) : swm_pkg::t_price'($urandom));
        end
    endtask

    // Zero acts as a window of one: each beat after the first reports the previous price.
    task automatic test_zero_length();
        set_window_len(swm_pkg::t_cfg'(0));
        send_price('0);
        send_price('1);
        send_price(32'h8000_0000);
        send_price(32'h0000_0001);
    endtask

    // A write with a partly filled window must empty it.
    task automatic test_rewrite_empties();
        set_window_len(swm_pkg::t_cfg'(3));
        send_price(32'h1234_5678);
        set_window_len(swm_pkg::t_cfg'(1));
        send_price(32'hffff_0000);
        send_price(32'h0000_ffff);
    endtask

    task automatic test_output_backpressure();
        set_window_len(swm_pkg::t_cfg'(3));
        set_pacing(PACE_FULL);
        @(negedge i_clk);
        hold_reqs++;
        @(posedge i_clk);
        for (int i = 0; i < 30; i++) begin
            send_price(rand_price());
        end
    endtask

    task automatic test_random_phases();
        int            sent;
        int            phase;
        int            count;
        int            pick;
        swm_pkg::t_cfg len;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: len = swm_pkg::t_cfg'(MAX_WINDOW);
                1: len = '1;
                2: len = swm_pkg::t_cfg'(MAX_WINDOW + 1);
                3: len = swm_pkg::t_cfg'(1);
                default: begin
                    pick = $urandom_range(99);
                    if (pick < 55) begin
                        len = swm_pkg::t_cfg'($urandom_range(1, 8));
                    end else if (pick < 80) begin
                        len = swm_pkg::t_cfg'($urandom_range(9, 32));
                    end else if (pick < 90) begin
                        len = swm_pkg::t_cfg'($urandom_range(33, MAX_WINDOW));
                    end else if (pick < 95) begin
                        len = swm_pkg::t_cfg'($urandom_range(MAX_WINDOW + 1, 127));
                    end else begin
                        len = '0;
                    end
                end
            endcase
            set_pacing(t_pace_mode'(phase % 4));
            set_window_len(len);
            count = int'(clamp_len(len)) + int'($urandom_range(1, 30));
            for (int i = 0; i < count; i++) begin
                send_price(rand_price());
            end
            sent += count;
            phase++;
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            ring_price[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_length();
        test_zero_length();
        test_rewrite_empties();
        test_output_backpressure();
        test_random_phases();

        set_pacing(PACE_FULL);
        wait_drained();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
